[rtl/fpp_pkg.sv]
package fpp_pkg;

    localparam int IDX_W   = 6;          // channel index field width
    localparam int CNT_W   = IDX_W + 1;  // channel count width (holds 64)
    localparam int VAL_W   = 8;          // int8 data
    localparam int IDX_SPAN = 1 << IDX_W;
    localparam int ACC_W   = 2 * VAL_W + IDX_W + 1;

    localparam int DEF_MAX_IN  = 64;
    localparam int DEF_MAX_MID = 64;
    localparam int DEF_MAX_OUT = 64;

    localparam int SAT_LO = -128;
    localparam int SAT_HI = 127;

    typedef enum logic [1:0] {
        OP_LOAD_W1 = 2'd0,
        OP_LOAD_W2 = 2'd1,
        OP_ACT     = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_IN_CH  = 2'd0,
        REG_MID_CH = 2'd1,
        REG_OUT_CH = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    // control tag that travels with one pair of MAC operands
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_ctl_t;

    // zero counts as one, anything above the limit is clamped to it
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r,
                                                   input logic [CNT_W-1:0] lim);
        logic [CNT_W-1:0] v;
        begin
            if (r == '0) begin
                v = CNT_W'(1);
            end else if (r > lim) begin
                v = lim;
            end else begin
                v = r;
            end
            return v;
        end
    endfunction

endpackage

[rtl/fpp_ram.sv]
module fpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/fpp_mac.sv]
module fpp_mac (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fpp_pkg::mac_ctl_t             ctl,
    input  logic signed [fpp_pkg::VAL_W-1:0] op_a,
    input  logic signed [fpp_pkg::VAL_W-1:0] op_b,
    output logic                          done,
    output logic signed [fpp_pkg::VAL_W-1:0] result
);
    import fpp_pkg::*;

    // stage 1: product
    logic signed [2*VAL_W-1:0] prod_reg;
    mac_ctl_t                  ctl1_reg;
    // stage 2: accumulate
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            ctl1_reg <= ctl;
            done_reg <= ctl1_reg.vld & ctl1_reg.last;
        end
    end

    always_comb begin
        if (ctl1_reg.first) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (ctl1_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    // saturate to int8
    always_comb begin
        if (acc_reg < ACC_W'(SAT_LO)) begin
            result = VAL_W'(SAT_LO);
        end else if (acc_reg > ACC_W'(SAT_HI)) begin
            result = VAL_W'(SAT_HI);
        end else begin
            result = acc_reg[VAL_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

[rtl/fused_pointwise_pair_int8.sv]
// Channel   | Dir | Signals                                | Payload
// ----------+-----+----------------------------------------+--------------------------------
// s_ (in)   | in  | s_tvalid s_tready s_tdata[23:0] s_tuser | tuser: operation; tdata: see port
// m_ (out)  | out | m_tvalid m_tready m_tdata[15:0] m_tlast | tdata: value, channel; tlast: last
// cfg       | in  | cfg_wr_en cfg_addr cfg_wdata            | channel count registers
//
// Weight loads and non-final row elements are accepted back to back while the block is idle.
// The element for the last input channel starts a compute run on one shared MAC,
// which reads its operands from weight and vector memories with one read per cycle;
// s_tready is low while the run lasts.
// Each result waits in the output register; a stalled m_tready holds the MAC sequencer.
// Reset is synchronous (aresetn low); memories are not cleared.
module fused_pointwise_pair_int8 #(
    parameter int MAX_IN  = fpp_pkg::DEF_MAX_IN,
    parameter int MAX_MID = fpp_pkg::DEF_MAX_MID,
    parameter int MAX_OUT = fpp_pkg::DEF_MAX_OUT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // config write port
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_addr,
    input  logic [fpp_pkg::CNT_W-1:0]   cfg_wdata,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,  // [5:0] first_index, [11:6] second_index,
                                                  // [19:12] item_value, [23:20] zero
    input  logic [1:0]                  s_tuser,  // [1:0] operation
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,  // [7:0] out_value, [13:8] out_channel,
                                                  // [15:14] zero
    output logic                        m_tlast   // last_of_row
);
    import fpp_pkg::*;

    // usable storage depth per dimension (indexes are only IDX_W bits)
    localparam int IN_D  = (MAX_IN  < IDX_SPAN) ? MAX_IN  : IDX_SPAN;
    localparam int MID_D = (MAX_MID < IDX_SPAN) ? MAX_MID : IDX_SPAN;
    localparam int OUT_D = (MAX_OUT < IDX_SPAN) ? MAX_OUT : IDX_SPAN;
    localparam int IN_W  = (IN_D  > 1) ? $clog2(IN_D)  : 1;
    localparam int MID_W = (MID_D > 1) ? $clog2(MID_D) : 1;
    localparam int OUT_W = (OUT_D > 1) ? $clog2(OUT_D) : 1;
    localparam int W1_AW = IN_W + MID_W;
    localparam int W2_AW = MID_W + OUT_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MAC1  = 6'b000010,  // issue layer-1 dot product terms
        ST_WAIT1 = 6'b000100,  // drain MAC, write mid entry
        ST_MAC2  = 6'b001000,  // issue layer-2 dot product terms
        ST_WAIT2 = 6'b010000,  // drain MAC
        ST_EMIT  = 6'b100000   // hand result to output register
    } state_t;

    // ---------------- configuration ----------------
    logic [CNT_W-1:0] in_ch_reg, mid_ch_reg, out_ch_reg;
    logic [CNT_W-1:0] nin, nmid, nout;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ch_reg  <= CNT_W'(1);
            mid_ch_reg <= CNT_W'(1);
            out_ch_reg <= CNT_W'(1);
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_IN_CH:  in_ch_reg  <= cfg_wdata;
                REG_MID_CH: mid_ch_reg <= cfg_wdata;
                REG_OUT_CH: out_ch_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign nin  = eff_count(in_ch_reg,  CNT_W'(IN_D));
    assign nmid = eff_count(mid_ch_reg, CNT_W'(MID_D));
    assign nout = eff_count(out_ch_reg, CNT_W'(OUT_D));

    // ---------------- input transaction decode ----------------
    logic [IDX_W-1:0] s_first_idx, s_second_idx;
    logic [VAL_W-1:0] s_value;
    op_t              s_op;
    logic             s_acc;

    assign s_first_idx  = s_tdata[5:0];
    assign s_second_idx = s_tdata[11:6];
    assign s_value      = s_tdata[19:12];
    assign s_op         = op_t'(s_tuser);

    state_t state_reg, state_next;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid & s_tready;

    logic a_in_ok, a_mid_ok, b_mid_ok, b_out_ok;
    assign a_in_ok  = ({1'b0, s_first_idx}  < CNT_W'(IN_D));
    assign a_mid_ok = ({1'b0, s_first_idx}  < CNT_W'(MID_D));
    assign b_mid_ok = ({1'b0, s_second_idx} < CNT_W'(MID_D));
    assign b_out_ok = ({1'b0, s_second_idx} < CNT_W'(OUT_D));

    logic w1_we, w2_we, row_we, row_last;
    assign w1_we    = s_acc && (s_op == OP_LOAD_W1) && a_in_ok && b_mid_ok;
    assign w2_we    = s_acc && (s_op == OP_LOAD_W2) && a_mid_ok && b_out_ok;
    assign row_we   = s_acc && (s_op == OP_ACT) && a_in_ok;
    assign row_last = row_we && ({1'b0, s_first_idx} == nin - CNT_W'(1));

    // ---------------- sequencer ----------------
    logic [IDX_W-1:0] k_reg, k_next;   // inner (summed) index
    logic [IDX_W-1:0] j_reg, j_next;   // outer (produced) index
    logic [CNT_W-1:0] k_lim, j_lim;
    logic             k_end, j_end, layer2;
    mac_ctl_t         issue_ctl, ctl_q_reg;

    logic                    mac_done;
    logic signed [VAL_W-1:0] mac_res;
    logic [VAL_W-1:0]        res_reg, res_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0] m_value_reg, m_value_next;
    logic [IDX_W-1:0] m_chan_reg, m_chan_next;
    logic             m_last_reg, m_last_next;
    logic             mid_we;

    assign layer2 = (state_reg == ST_MAC2) || (state_reg == ST_WAIT2) || (state_reg == ST_EMIT);
    assign k_lim  = layer2 ? nmid : nin;
    assign j_lim  = layer2 ? nout : nmid;
    assign k_end  = ({1'b0, k_reg} == k_lim - CNT_W'(1));
    assign j_end  = ({1'b0, j_reg} == j_lim - CNT_W'(1));

    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        res_next      = res_reg;
        issue_ctl     = '0;
        mid_we        = 1'b0;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_value_next  = m_value_reg;
        m_chan_next   = m_chan_reg;
        m_last_next   = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (row_last) begin
                    k_next     = '0;
                    j_next     = '0;
                    state_next = ST_MAC1;
                end
            end
            ST_MAC1, ST_MAC2: begin
                issue_ctl.vld   = 1'b1;
                issue_ctl.first = (k_reg == '0);
                issue_ctl.last  = k_end;
                k_next          = k_reg + 1'b1;
                if (k_end) begin
                    state_next = (state_reg == ST_MAC1) ? ST_WAIT1 : ST_WAIT2;
                end
            end
            ST_WAIT1: begin
                if (mac_done) begin
                    mid_we = 1'b1;
                    k_next = '0;
                    if (j_end) begin
                        j_next     = '0;
                        state_next = ST_MAC2;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_MAC1;
                    end
                end
            end
            ST_WAIT2: begin
                if (mac_done) begin
                    res_next   = mac_res;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = res_reg;
                    m_chan_next   = j_reg;
                    m_last_next   = j_end;
                    k_next        = '0;
                    if (j_end) begin
                        state_next = ST_IDLE;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_MAC2;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ctl_q_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ctl_q_reg    <= issue_ctl;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        j_reg       <= j_next;
        res_reg     <= res_next;
        m_value_reg <= m_value_next;
        m_chan_reg  <= m_chan_next;
        m_last_reg  <= m_last_next;
    end

    // ---------------- storage ----------------
    logic [VAL_W-1:0] row_q, mid_q, w1_q, w2_q;

    fpp_ram #(.WIDTH(VAL_W), .DEPTH(IN_D)) u_row (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (s_first_idx[IN_W-1:0]),
        .wdata (s_value),
        .raddr (k_reg[IN_W-1:0]),
        .rdata (row_q)
    );

    fpp_ram #(.WIDTH(VAL_W), .DEPTH(MID_D)) u_mid (
        .aclk  (aclk),
        .we    (mid_we),
        .waddr (j_reg[MID_W-1:0]),
        .wdata (mac_res),
        .raddr (k_reg[MID_W-1:0]),
        .rdata (mid_q)
    );

    // first weights addressed {input channel, mid channel}
    fpp_ram #(.WIDTH(VAL_W), .DEPTH(1 << W1_AW)) u_w1 (
        .aclk  (aclk),
        .we    (w1_we),
        .waddr ({s_first_idx[IN_W-1:0], s_second_idx[MID_W-1:0]}),
        .wdata (s_value),
        .raddr ({k_reg[IN_W-1:0], j_reg[MID_W-1:0]}),
        .rdata (w1_q)
    );

    // second weights addressed {mid channel, output channel}
    fpp_ram #(.WIDTH(VAL_W), .DEPTH(1 << W2_AW)) u_w2 (
        .aclk  (aclk),
        .we    (w2_we),
        .waddr ({s_first_idx[MID_W-1:0], s_second_idx[OUT_W-1:0]}),
        .wdata (s_value),
        .raddr ({k_reg[MID_W-1:0], j_reg[OUT_W-1:0]}),
        .rdata (w2_q)
    );

    // ---------------- shared MAC ----------------
    logic signed [VAL_W-1:0] op_a, op_b;
    assign op_a = layer2 ? mid_q : row_q;
    assign op_b = layer2 ? w2_q  : w1_q;

    fpp_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl_q_reg),
        .op_a    (op_a),
        .op_b    (op_b),
        .done    (mac_done),
        .result  (mac_res)
    );

    // ---------------- result port ----------------
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_chan_reg, m_value_reg};
    assign m_tlast  = m_last_reg;

endmodule

[dv/fused_pointwise_pair_int8_test.sv]
`timescale 1ns / 1ps

module fused_pointwise_pair_int8_test;
    import fpp_pkg::*;

    localparam int CH_LIMIT      = 64;       // storage depth per channel axis
    localparam int IDLE_PCT      = 26;       // chance in 100 that a side idles a cycle
    localparam int RANDOM_ITEMS  = 350;      // stop adding random phases past this
    localparam int SETTLE_CYCLES = 16;       // quiet cycles before a register write
    localparam int DRAIN_CYCLES  = 32;       // quiet cycles at the end of the run
    localparam int DRAIN_LIMIT   = 100000;   // bound on the end-of-run wait
    localparam int CALM_FROM     = 500;      // cycle window with no idling on
    localparam int CALM_TO       = 1500;     // either side
    localparam int RUN_LIMIT_NS  = 40000000; // hard time limit in ns, far past the slowest run
    localparam int MAX_REPORTS   = 40;

    // one entry of the stimulus queue: a register write or an input transaction
    typedef struct {
        bit                      reg_write;
        reg_idx_t                addr;
        logic [CNT_W-1:0]        wdata;
        op_t                     op;
        logic [IDX_W-1:0]        idx1;
        logic [IDX_W-1:0]        idx2;
        logic signed [VAL_W-1:0] val;
    } feed_t;

    // one expected output transaction
    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        chan;
        logic                    last;
    } out_rec_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_addr  = '0;
    logic [CNT_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [23:0]        s_tdata   = '0;   // [5:0] first_index, [11:6] second_index,
                                          // [19:12] item_value, [23:20] zero
    logic [1:0]         s_tuser   = '0;   // [1:0] operation
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [15:0]        m_tdata;          // [7:0] out_value, [13:8] out_channel,
                                          // [15:14] zero
    logic               m_tlast;

    fused_pointwise_pair_int8 u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: channel registers, both weight memories, the row
    // buffer and the intermediate vector, updated per accepted transaction.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]        in_reg  = CNT_W'(1);
    logic [CNT_W-1:0]        mid_reg = CNT_W'(1);
    logic [CNT_W-1:0]        out_reg = CNT_W'(1);
    logic signed [VAL_W-1:0] act_row [CH_LIMIT];
    logic signed [VAL_W-1:0] mid_vec [CH_LIMIT];
    logic signed [VAL_W-1:0] w1_mem  [CH_LIMIT][CH_LIMIT];
    logic signed [VAL_W-1:0] w2_mem  [CH_LIMIT][CH_LIMIT];

    out_rec_t pending_outputs [$];    // results still owed by the block
    feed_t    feed_q [$];             // stimulus not yet driven
    feed_t    s_item;                 // transaction currently on the input bus
    bit       s_took       = 1'b0;    // input handshake at the last rising edge
    int       quiet_cycles = 0;       // cycles with neither valid high
    int       cyc          = 0;
    int       mismatch_cnt = 0;

    // stimulus-side bookkeeping: what has been written, so that no compute
    // ever reads a weight or row entry that was never loaded
    bit have_w1  [CH_LIMIT][CH_LIMIT];
    bit have_w2  [CH_LIMIT][CH_LIMIT];
    bit have_row [CH_LIMIT];
    int gen_nin  = 1;
    int gen_nmid = 1;
    int gen_nout = 1;
    int item_count = 0;

    // zero means one, anything past the storage depth is clamped to it
    function automatic int used_count(input logic [CNT_W-1:0] r);
        if (r == '0) return 1;
        if (r > CH_LIMIT) return CH_LIMIT;
        return int'(r);
    endfunction

    function automatic logic signed [VAL_W-1:0] clip_int8(input int v);
        if (v < SAT_LO) return VAL_W'(SAT_LO);
        if (v > SAT_HI) return VAL_W'(SAT_HI);
        return VAL_W'(v);
    endfunction

    function automatic bit in_calm();
        return cyc >= CALM_FROM && cyc < CALM_TO;
    endfunction

    // Both layers run when the element for the last input channel lands;
    // every other element only updates the row buffer.
    task automatic predict_pointwise(input feed_t f);
        int       nin;
        int       nmid;
        int       nout;
        int       acc;
        out_rec_t r;
        case (f.op)
            OP_LOAD_W1: w1_mem[f.idx1][f.idx2] = f.val;
            OP_LOAD_W2: w2_mem[f.idx1][f.idx2] = f.val;
            OP_ACT: begin
                act_row[f.idx1] = f.val;
                nin = used_count(in_reg);
                if (int'(f.idx1) == nin - 1) begin
                    nmid = used_count(mid_reg);
                    nout = used_count(out_reg);
                    for (int m = 0; m < nmid; m++) begin
                        acc = 0;
                        for (int i = 0; i < nin; i++)
                            acc += int'(act_row[i]) * int'(w1_mem[i][m]);
                        mid_vec[m] = clip_int8(acc);
                    end
                    for (int o = 0; o < nout; o++) begin
                        acc = 0;
                        for (int m = 0; m < nmid; m++)
                            acc += int'(mid_vec[m]) * int'(w2_mem[m][o]);
                        r.value = clip_int8(acc);
                        r.chan  = IDX_W'(o);
                        r.last  = (o == nout - 1);
                        pending_outputs.push_back(r);
                    end
                end
            end
            default: ;  // unused operation code is dropped
        endcase
    endtask

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Stimulus building, all done at time zero into feed_q
    // ------------------------------------------------------------------

    // value mix: full range, near zero (non-saturating sums), and the rails
    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r < 4) return VAL_W'($urandom_range(255));
        if (r < 8) return VAL_W'(int'($urandom_range(6)) - 3);
        if (r == 8) return VAL_W'(SAT_LO);
        return VAL_W'(SAT_HI);
    endfunction

    // mostly small channel counts; zero and mid-sized ones now and then
    function automatic int rand_count();
        int r;
        r = $urandom_range(99);
        if (r < 6) return 0;
        if (r < 12) return $urandom_range(20, 9);
        return $urandom_range(8, 1);
    endfunction

    task automatic push_item(input op_t op, input int i1, input int i2,
                             input logic signed [VAL_W-1:0] v);
        feed_t f;
        f.reg_write = 1'b0;
        f.addr      = REG_NONE;
        f.wdata     = '0;
        f.op        = op;
        f.idx1      = IDX_W'(i1);
        f.idx2      = IDX_W'(i2);
        f.val       = v;
        case (op)
            OP_LOAD_W1: have_w1[f.idx1][f.idx2] = 1'b1;
            OP_LOAD_W2: have_w2[f.idx1][f.idx2] = 1'b1;
            OP_ACT:     have_row[f.idx1] = 1'b1;
            default: ;
        endcase
        if (op != OP_NONE) item_count++;
        feed_q.push_back(f);
    endtask

    task automatic push_reg_write(input reg_idx_t r, input int v);
        feed_t f;
        f.reg_write = 1'b1;
        f.addr      = r;
        f.wdata     = CNT_W'(v);
        f.op        = OP_NONE;
        f.idx1      = '0;
        f.idx2      = '0;
        f.val       = '0;
        case (r)
            REG_IN_CH:  gen_nin  = used_count(f.wdata);
            REG_MID_CH: gen_nmid = used_count(f.wdata);
            REG_OUT_CH: gen_nout = used_count(f.wdata);
            default: ;
        endcase
        feed_q.push_back(f);
    endtask

    task automatic set_channels(input int nin_raw, input int nmid_raw, input int nout_raw);
        push_reg_write(REG_IN_CH, nin_raw);
        push_reg_write(REG_MID_CH, nmid_raw);
        push_reg_write(REG_OUT_CH, nout_raw);
    endtask

    // load every weight the current channel counts will read and that is still unset
    task automatic cover_weights();
        for (int i = 0; i < gen_nin; i++)
            for (int m = 0; m < gen_nmid; m++)
                if (!have_w1[i][m]) push_item(OP_LOAD_W1, i, m, pick_value());
        for (int m = 0; m < gen_nmid; m++)
            for (int o = 0; o < gen_nout; o++)
                if (!have_w2[m][o]) push_item(OP_LOAD_W2, m, o, pick_value());
    endtask

    // anything that must not start a compute: unused op, stray weight loads,
    // elements for channels past the last one in use
    task automatic push_noise();
        case ($urandom_range(3))
            0: push_item(OP_NONE, $urandom_range(63), $urandom_range(63),
                         VAL_W'($urandom_range(255)));
            1: push_item(OP_LOAD_W1, $urandom_range(63), $urandom_range(63), pick_value());
            2: push_item(OP_LOAD_W2, $urandom_range(63), $urandom_range(63), pick_value());
            default: begin
                if (gen_nin < CH_LIMIT)
                    push_item(OP_ACT, $urandom_range(63, gen_nin), $urandom_range(63),
                              pick_value());
                else
                    push_item(OP_NONE, $urandom_range(63), $urandom_range(63),
                              VAL_W'($urandom_range(255)));
            end
        endcase
    endtask

    // A clean row sends channels in order. A messy one shuffles them, skips
    // some that already hold a value, mixes in noise and may fire twice.
    task automatic push_row(input bit messy);
        int order [$];
        int k;
        int tmp;
        for (int c = 0; c < gen_nin - 1; c++)
            if (!have_row[c] || !messy || $urandom_range(99) < 80) order.push_back(c);
        if (messy) begin
            for (int j = order.size() - 1; j > 0; j--) begin
                k = $urandom_range(j);
                tmp = order[j];
                order[j] = order[k];
                order[k] = tmp;
            end
        end
        foreach (order[j]) begin
            push_item(OP_ACT, order[j], $urandom_range(63), pick_value());
            if (messy && $urandom_range(99) < 20) push_noise();
        end
        push_item(OP_ACT, gen_nin - 1, $urandom_range(63), pick_value());
        if (messy && $urandom_range(99) < 25)
            push_item(OP_ACT, gen_nin - 1, $urandom_range(63), pick_value());
    endtask

    // ------------------------------------------------------------------
    // Driver: the rising-edge half notes the handshake and runs the predictor,
    // the falling-edge half puts the next transaction or register write out.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        s_took = aresetn && s_tvalid && s_tready;
        if (s_took) predict_pointwise(s_item);
    end

    always @(negedge aclk) begin
        feed_t f;
        logic  valid_nx;
        logic  we_nx;
        we_nx    = 1'b0;
        valid_nx = s_tvalid;
        if (!aresetn) begin
            valid_nx = 1'b0;
        end else if (!s_tvalid || s_took) begin
            valid_nx = 1'b0;
            if (feed_q.size() != 0) begin
                if (feed_q[0].reg_write) begin
                    // registers change only with the block drained and settled
                    if (pending_outputs.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                        f = feed_q.pop_front();
                        we_nx = 1'b1;
                        cfg_addr  <= f.addr;
                        cfg_wdata <= f.wdata;
                        case (f.addr)
                            REG_IN_CH:  in_reg  = f.wdata;
                            REG_MID_CH: mid_reg = f.wdata;
                            REG_OUT_CH: out_reg = f.wdata;
                            default: ;  // no such register, write is dropped
                        endcase
                    end
                end else if (in_calm() || $urandom_range(99) >= IDLE_PCT) begin
                    s_item = feed_q.pop_front();
                    valid_nx = 1'b1;
                    s_tuser <= s_item.op;
                    s_tdata <= {4'b0, s_item.val, s_item.idx2, s_item.idx1};
                end
            end
        end
        s_tvalid  <= valid_nx;
        cfg_wr_en <= we_nx;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= aresetn && (in_calm() || $urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Monitor: every output transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_rec_t want;
        cyc++;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected result, tdata %h tlast %b",
                                          m_tdata, m_tlast));
            end else begin
                want = pending_outputs.pop_front();
                if ($signed(m_tdata[7:0]) != want.value)
                    report_mismatch($sformatf("out_value %0d, wanted %0d (channel %0d)",
                                              $signed(m_tdata[7:0]), want.value, want.chan));
                if (m_tdata[13:8] != want.chan)
                    report_mismatch($sformatf("out_channel %0d, wanted %0d",
                                              m_tdata[13:8], want.chan));
                if (m_tlast != want.last)
                    report_mismatch($sformatf("last_of_row %b, wanted %b (channel %0d)",
                                              m_tlast, want.last, want.chan));
            end
        end
        if (s_tvalid || m_tvalid) quiet_cycles = 0;
        else quiet_cycles++;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int wait_cnt;

        // Directed, at the reset counts of one channel each.
        // Unused op with every field bit set: dropped.
        push_item(OP_NONE, 63, 63, VAL_W'(-1));
        // both rails: the first row overflows high in layer one and low in layer two, the second the reverse
        push_item(OP_LOAD_W1, 0, 0, VAL_W'(SAT_LO));
        push_item(OP_LOAD_W2, 0, 0, VAL_W'(SAT_LO));
        push_item(OP_ACT, 0, 63, VAL_W'(SAT_LO));
        push_item(OP_ACT, 0, 0, VAL_W'(SAT_HI));
        // unit weights: plain pass-through, no saturation
        push_item(OP_LOAD_W1, 0, 0, VAL_W'(1));
        push_item(OP_LOAD_W2, 0, 0, VAL_W'(1));
        push_item(OP_ACT, 0, 21, VAL_W'(0));
        push_item(OP_ACT, 0, 42, VAL_W'(5));
        push_item(OP_ACT, 0, 0, VAL_W'(-7));
        // top-corner weight loads, and an element past the last channel: no result
        push_item(OP_LOAD_W1, 63, 63, VAL_W'(SAT_HI));
        push_item(OP_LOAD_W2, 63, 63, VAL_W'(SAT_LO));
        push_item(OP_ACT, 63, 0, VAL_W'(SAT_HI));
        push_item(OP_ACT, 0, 63, VAL_W'(3));

        // write to the missing register index is dropped; zero count acts as
        // one; a mid count over the limit clamps to 64
        push_reg_write(REG_NONE, 127);
        set_channels(0, 127, 1);
        cover_weights();
        repeat (2) push_row(1'b0);

        // output count over the limit clamps to 64
        set_channels(1, 1, 65);
        cover_weights();
        push_row(1'b0);

        // wide input clamped to 64, single mid and output channel
        set_channels(100, 1, 1);
        cover_weights();
        push_row(1'b0);

        // random phases: new counts, fill any missing weights, then rows
        while (item_count < RANDOM_ITEMS) begin
            set_channels(rand_count(), rand_count(), rand_count());
            cover_weights();
            repeat ($urandom_range(8, 3)) push_row($urandom_range(99) < 25);
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // feed_q and s_tvalid only move at falling edges
        do @(posedge aclk); while (feed_q.size() != 0 || s_tvalid);
        wait_cnt = 0;
        do begin
            @(negedge aclk);
            wait_cnt++;
        end while ((pending_outputs.size() != 0 || quiet_cycles < DRAIN_CYCLES)
                   && wait_cnt < DRAIN_LIMIT);
        if (pending_outputs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_outputs.size()));

        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hard stop for a hung handshake
    initial begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
